/* rtl/core/bls_pkg.sv */
`timescale 1ns / 1ps

package bls_pkg;

    // Default width of the line counter
    localparam int LINE_BITS_DEF = 16;

    // Scanner mode codes
    localparam logic [2:0] MODE_CODE  = 3'd0;
    localparam logic [2:0] MODE_STR   = 3'd1;
    localparam logic [2:0] MODE_LINE  = 3'd2;
    localparam logic [2:0] MODE_BLOCK = 3'd3;

    // Characters of interest
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;

    // Result flags from the scanner to the output stage
    typedef struct packed {
        logic emit;
        logic brace;
    } t_scan_res;

endpackage

/* rtl/core/bls_scanner.sv */
`timescale 1ns / 1ps

module bls_scanner
    import bls_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output t_scan_res            o_res,
    output logic [LINE_BITS-1:0] o_line
);

    logic [2:0]           r_mode, n_mode;
    logic                 r_held, n_held;
    logic [LINE_BITS-1:0] r_line, n_line;
    logic                 r_done, n_done;

    always_comb begin
        logic                 cont;
        logic                 bump;
        logic                 brace;
        logic [2:0]           mode;
        logic [LINE_BITS-1:0] line_out;
        n_mode   = r_mode;
        n_held   = r_held;
        n_line   = r_line;
        n_done   = r_done;
        cont     = 1'b1;
        bump     = 1'b0;
        brace    = 1'b0;
        mode     = r_mode;
        line_out = r_line;
        o_res    = '0;

        if (r_done) begin
            // drop bytes until the end of the text
            if (i_last) begin
                n_done = 1'b0;
            end
        end else begin
            // resolve the held byte first
            if (r_held) begin
                n_held = 1'b0;
                case (mode)
                    MODE_STR: begin
                        if (i_byte == CH_QUOTE) cont = 1'b0;
                    end
                    MODE_BLOCK: begin
                        if (i_byte == CH_SLASH) mode = MODE_CODE;
                    end
                    MODE_LINE: begin
                    end
                    default: begin
                        if (i_byte == CH_SLASH) begin
                            mode = MODE_LINE;
                            cont = 1'b0;
                        end else if (i_byte == CH_STAR) begin
                            mode = MODE_BLOCK;
                            cont = 1'b0;
                        end
                    end
                endcase
            end

            if (cont) begin
                case (mode)
                    MODE_STR: begin
                        if (i_byte == CH_NL) bump = 1'b1;
                        else if (i_byte == CH_BSLASH) n_held = 1'b1;
                        else if (i_byte == CH_QUOTE) mode = MODE_CODE;
                        else if (i_byte == CH_LBRACE) brace = 1'b1;
                    end
                    MODE_LINE: begin
                        if (i_byte == CH_NL) begin
                            bump = 1'b1;
                            mode = MODE_CODE;
                        end
                    end
                    MODE_BLOCK: begin
                        if (i_byte == CH_NL) bump = 1'b1;
                        else if (i_byte == CH_STAR) n_held = 1'b1;
                    end
                    default: begin
                        if (i_byte == CH_NL) bump = 1'b1;
                        else if (i_byte == CH_QUOTE) mode = MODE_STR;
                        else if (i_byte == CH_SLASH) n_held = 1'b1;
                        else if (i_byte == CH_LBRACE) brace = 1'b1;
                    end
                endcase
            end

            // an open line comment at the end counts one more line
            if (!brace && i_last && mode == MODE_LINE) bump = 1'b1;

            if (bump && r_line != {LINE_BITS{1'b1}}) begin
                line_out = r_line + {{(LINE_BITS-1){1'b0}}, 1'b1};
            end

            n_mode = mode;
            n_line = line_out;
            o_res.emit  = brace | i_last;
            o_res.brace = brace;
            if (brace && !i_last) n_done = 1'b1;
        end

        // re-arm after the final byte
        if (i_last) begin
            n_mode = MODE_CODE;
            n_held = 1'b0;
            n_line = {{(LINE_BITS-1){1'b0}}, 1'b1};
            n_done = 1'b0;
        end

        o_line = line_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CODE;
            r_held <= 1'b0;
            r_line <= {{(LINE_BITS-1){1'b0}}, 1'b1};
            r_done <= 1'b0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_held <= n_held;
            r_line <= n_line;
            r_done <= n_done;
        end
    end

endmodule

/* rtl/core/brace_line_comment_scanner.sv */
`timescale 1ns / 1ps
// A byte passes the input register, then the result register, before its result
//   appears. Throughput: one byte per cycle while the output is not stalled;
//   the mode machine resolves each byte in one pass.
// Reset: synchronous, active low; clears both pipeline valids and returns the
//   scanner to code mode with the line count at one.

module brace_line_comment_scanner
    import bls_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_text_byte,
    input  logic                 i_last_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [LINE_BITS-1:0] o_line_number,
    output logic                 o_brace_found
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_last;

    // Result register
    logic                 r_out_valid;
    logic [LINE_BITS-1:0] r_line;
    logic                 r_brace;

    logic                 advance;
    logic                 out_take;
    t_scan_res            res;
    logic [LINE_BITS-1:0] res_line;

    // Advance the held byte when the result register is free or empties now
    assign out_take   = r_out_valid & ~i_out_stall;
    assign advance    = r_in_valid & (~r_out_valid | ~i_out_stall);
    // Stall input only while a byte is held and cannot advance
    assign o_in_stall = r_in_valid & ~advance;

    bls_scanner #(
        .LINE_BITS(LINE_BITS)
    ) u_scanner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_byte),
        .i_last  (r_last),
        .o_res   (res),
        .o_line  (res_line)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Hold the payload while stalled; load on every open cycle
    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_byte <= i_text_byte;
            r_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res.emit) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.emit) begin
            r_line  <= res_line;
            r_brace <= res.brace;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_line_number = r_line;
    assign o_brace_found = r_brace;

endmodule
